FILE: rtl/esd_pkg.sv
// Package for the escape sequence decoder: decode modes, character codes
// and the UTF-8 encoder. No dependencies.
package esd_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam int MaxResults = 3;

  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_N      = 8'h6E;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_E      = 8'h65;
  localparam byte_t CH_U      = 8'h75;
  localparam byte_t CODE_LF   = 8'h0A;
  localparam byte_t CODE_CR   = 8'h0D;
  localparam byte_t CODE_TAB  = 8'h09;
  localparam byte_t CODE_ESC  = 8'h1B;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  // Up to three result bytes, first in b[0]
  typedef struct packed {
    logic [1:0] cnt;
    byte_t [2:0] b;
  } burst_t;

  function automatic burst_t utf8_encode(input logic [15:0] cp);
    burst_t r;
    r = '0;
    if (cp < 16'h0080) begin
      r.cnt  = 2'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      r.cnt  = 2'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else begin
      r.cnt  = 2'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/escape_sequence_decoder.sv
// Escape sequence decoder top level: decode logic and result register.
// Depends on esd_pkg.

// Decodes backslash escapes of a quoted string, one source byte per
// transaction on the in_ channel, and returns the decoded bytes on the out_
// channel with out_tlast marking the last byte caused by each source byte.
// A source byte is accepted every cycle while the output is not stalled and
// it yields at most one result byte; a \u group ending in a two- or three-byte
// UTF-8 sequence holds off the next source byte while the three-entry result
// register drains. The first result byte appears the cycle after the accept.
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  esd_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;          // \u group bytes consumed
  logic [15:0] code_r, code_nxt;
  logic        neg_r, neg_nxt;
  logic        saw_r, saw_nxt;
  logic        stop_r, stop_nxt;

  logic [1:0]  res_cnt_r, res_cnt_nxt;  // result bytes still pending
  esd_pkg::byte_t [2:0] res_b_r, res_b_nxt;

  esd_pkg::burst_t burst;
  logic        in_hs, out_hs;
  logic [3:0]  digit;
  logic        is_digit;

  assign in_hs  = in_tvalid & in_tready;
  assign out_hs = out_tvalid & out_tready;

  assign in_tready  = (res_cnt_r == 2'd0) || (res_cnt_r == 2'd1 && out_tready);
  assign out_tvalid = (res_cnt_r != 2'd0);
  assign out_tdata  = res_b_r[0];
  assign out_tlast  = (res_cnt_r == 2'd1);

  always_comb begin
    is_digit = 1'b1;
    digit    = '0;
    if (in_tdata >= 8'h30 && in_tdata <= 8'h39) begin
      digit = in_tdata[3:0];
    end else if ((in_tdata >= 8'h61 && in_tdata <= 8'h66) ||
                 (in_tdata >= 8'h41 && in_tdata <= 8'h46)) begin
      digit = in_tdata[3:0] + 4'd9;
    end else begin
      is_digit = 1'b0;
    end
  end

  // Next state and burst for the byte at the input
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    neg_nxt  = neg_r;
    saw_nxt  = saw_r;
    stop_nxt = stop_r;
    burst    = '0;
    case (mode_r)
      esd_pkg::MODE_ESC: begin
        mode_nxt = esd_pkg::MODE_PLAIN;
        burst.cnt = 2'd1;
        case (in_tdata)
          esd_pkg::CH_N: burst.b[0] = esd_pkg::CODE_LF;
          esd_pkg::CH_R: burst.b[0] = esd_pkg::CODE_CR;
          esd_pkg::CH_T: burst.b[0] = esd_pkg::CODE_TAB;
          esd_pkg::CH_E: burst.b[0] = esd_pkg::CODE_ESC;
          esd_pkg::CH_U: begin
            cnt_nxt  = '0;
            code_nxt = '0;
            neg_nxt  = 1'b0;
            saw_nxt  = 1'b0;
            stop_nxt = 1'b0;
            if (in_tlast) begin
              burst = esd_pkg::utf8_encode(esd_pkg::REPLACEMENT);
            end else begin
              burst.cnt = 2'd0;
              mode_nxt  = esd_pkg::MODE_HEX;
            end
          end
          default: burst.b[0] = in_tdata;
        endcase
      end
      esd_pkg::MODE_HEX: begin
        if (!stop_r) begin
          if (cnt_r == 2'd0 && in_tdata == esd_pkg::CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (is_digit) begin
            code_nxt = {code_r[11:0], digit};
            saw_nxt  = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3 || in_tlast) begin
          mode_nxt = esd_pkg::MODE_PLAIN;
          if (cnt_r != 2'd3 || !saw_nxt) begin
            // group cut short, or no digits at all
            burst = esd_pkg::utf8_encode(esd_pkg::REPLACEMENT);
          end else if (neg_nxt) begin
            burst.cnt  = 2'd1;
            burst.b[0] = 8'd0 - code_nxt[7:0];
          end else begin
            burst = esd_pkg::utf8_encode(code_nxt);
          end
        end
      end
      default: begin
        mode_nxt = esd_pkg::MODE_PLAIN;
        if (in_tdata == esd_pkg::CH_BSLASH) begin
          if (!in_tlast) mode_nxt = esd_pkg::MODE_ESC;
        end else begin
          burst.cnt  = 2'd1;
          burst.b[0] = in_tdata;
        end
      end
    endcase
    if (mode_nxt != esd_pkg::MODE_HEX || in_tlast) begin
      mode_nxt = (mode_nxt == esd_pkg::MODE_ESC && !in_tlast) ? esd_pkg::MODE_ESC
                                                              : esd_pkg::MODE_PLAIN;
      cnt_nxt  = '0;
    end
  end

  // Result register: loads a burst, shifts one byte out per transaction
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    res_b_nxt   = res_b_r;
    if (in_hs) begin
      res_cnt_nxt = burst.cnt;
      res_b_nxt   = burst.b;
    end else if (out_hs) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
      res_b_nxt   = {res_b_r[2], res_b_r[2], res_b_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= esd_pkg::MODE_PLAIN;
      cnt_r     <= '0;
      code_r    <= '0;
      neg_r     <= 1'b0;
      saw_r     <= 1'b0;
      stop_r    <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (in_hs) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        // hex accumulator is cleared whenever a group starts or ends
        if (mode_nxt == esd_pkg::MODE_HEX) begin
          code_r <= code_nxt;
          neg_r  <= neg_nxt;
          saw_r  <= saw_nxt;
          stop_r <= stop_nxt;
        end else begin
          code_r <= '0;
          neg_r  <= 1'b0;
          saw_r  <= 1'b0;
          stop_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_b_r <= res_b_nxt;
  end

endmodule

FILE: rtl/esd_checker.sv
// Port-level checks for escape_sequence_decoder, bound to the top level.
// Uses only the top level's ports, no package.
module esd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Waiting source byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("source byte changed while waiting");

  // No new source byte while more than one result byte is pending
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready during a multi-byte burst");

  // Last pending byte stalled: input must wait
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tready |-> !in_tready)
    else $error("input ready with a stalled result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
